// ----- hw/rtl/keyframe_curve_interpolator_macros.svh -----
// Assertion helpers for the interpolator checker.
// Both expect clk_i and rst_ni in scope.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/kci_pkg.sv -----
`timescale 1ns / 1ps
package kci_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int BISECT_STEPS = 8;

  localparam int FRAME_W = 16;
  localparam int VAL_W   = 32;
  localparam int REM_W   = FRAME_W + 1;
  // ratio, u, v and the unit-range weights
  localparam int UW      = FRAC_BITS + 1;
  // weights carrying a factor of three
  localparam int WW      = FRAC_BITS + 2;
  // span and shifted end control time
  localparam int XW      = ((FRAME_W + FRAC_BITS > VAL_W) ? FRAME_W + FRAC_BITS : VAL_W) + 2;
  localparam int TW      = FRAME_W + UW;
  localparam int QW      = VAL_W + 1;
  localparam int CW      = FRAC_BITS + 4;
  localparam int ACC_W   = WW + 1 + XW + 2;

  localparam logic [UW-1:0] ONE_FX = UW'(1) << FRAC_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    K_HOLD    = 2'd0,
    K_LINEAR  = 2'd1,
    K_HERMITE = 2'd2,
    K_BEZIER  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [FRAME_W-1:0]        ff;
    logic [FRAME_W-1:0]        bf;
    logic [FRAME_W-1:0]        fn;
    logic signed [VAL_W-1:0]   f;
    logic signed [VAL_W-1:0]   b;
    logic signed [VAL_W-1:0]   st;
    logic signed [VAL_W-1:0]   sv;
    logic signed [VAL_W-1:0]   et;
    logic signed [VAL_W-1:0]   ev;
  } raw_t;

  typedef struct packed {
    kind_e                     kind;
    logic                      pass;
    logic [FRAME_W-1:0]        d;
    logic signed [VAL_W-1:0]   f;
    logic signed [VAL_W-1:0]   b;
    logic signed [VAL_W-1:0]   st;
    logic signed [VAL_W-1:0]   sv;
    logic signed [VAL_W-1:0]   et;
    logic signed [VAL_W-1:0]   ev;
  } item_t;

  typedef struct packed {
    item_t           it;
    logic [UW-1:0]   r;
  } fe_item_t;

endpackage

// ----- hw/rtl/kci_front.sv -----
`timescale 1ns / 1ps
module kci_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kci_pkg::raw_t     raw_i,
  output logic              push_o,
  input  logic              full_i,
  output kci_pkg::fe_item_t item_o
);
  import kci_pkg::*;

  typedef struct packed {
    item_t                 it;
    logic [REM_W-1:0]      rem;
    logic [FRAC_BITS-1:0]  quo;
    logic                  one;
  } dv_t;

  dv_t                dv_d [FRAC_BITS+1];
  dv_t                dv_q [FRAC_BITS+1];
  logic [FRAC_BITS:0] vld_q;
  logic               en;
  logic [FRAME_W:0]   num;
  logic               nonpos;
  logic               ge;
  logic [REM_W-1:0]   rem2;

  assign en         = !vld_q[FRAC_BITS] || !full_i;
  assign in_ready_o = en;

  always_comb begin
    num    = {1'b0, raw_i.fn} - {1'b0, raw_i.ff};
    nonpos = num[FRAME_W] || (num == '0);
    dv_d[0].it.kind = raw_i.kind;
    dv_d[0].it.pass = (raw_i.bf <= raw_i.ff) || (raw_i.kind == K_HOLD);
    dv_d[0].it.d    = raw_i.bf - raw_i.ff;
    dv_d[0].it.f    = raw_i.f;
    dv_d[0].it.b    = raw_i.b;
    dv_d[0].it.st   = raw_i.st;
    dv_d[0].it.sv   = raw_i.sv;
    dv_d[0].it.et   = raw_i.et;
    dv_d[0].it.ev   = raw_i.ev;
    ge = !nonpos && (num[FRAME_W-1:0] >= dv_d[0].it.d);
    // clamped ratios run through the divider with a zero remainder
    dv_d[0].rem = (nonpos || ge) ? '0 : REM_W'(num[FRAME_W-1:0]);
    dv_d[0].quo = '0;
    dv_d[0].one = ge;
    rem2 = '0;
    // restoring division, one quotient bit per stage
    for (int s = 1; s <= FRAC_BITS; s++) begin
      dv_d[s] = dv_q[s-1];
      rem2    = {dv_q[s-1].rem[REM_W-2:0], 1'b0};
      if (rem2 >= REM_W'(dv_q[s-1].it.d)) begin
        dv_d[s].rem = rem2 - REM_W'(dv_q[s-1].it.d);
        dv_d[s].quo = {dv_q[s-1].quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        dv_d[s].rem = rem2;
        dv_d[s].quo = {dv_q[s-1].quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FRAC_BITS-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q <= dv_d;
    end
  end

  assign push_o    = vld_q[FRAC_BITS] && !full_i;
  assign item_o.it = dv_q[FRAC_BITS].it;
  assign item_o.r  = dv_q[FRAC_BITS].one ? ONE_FX : {1'b0, dv_q[FRAC_BITS].quo};

endmodule

// ----- hw/rtl/kci_fifo.sv -----
`timescale 1ns / 1ps
module kci_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kci_pkg::fe_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output kci_pkg::fe_item_t data_o
);
  import kci_pkg::*;

  fe_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, wr_d;
  logic [FIFO_AW-1:0]   rd_q, rd_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // depth is a power of two, pointers wrap on their own
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/kci_back.sv -----
`timescale 1ns / 1ps
module kci_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          pop_o,
  input  kci_pkg::fe_item_t             item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [kci_pkg::VAL_W-1:0] result_o
);
  import kci_pkg::*;

  localparam int BZ_STG = 4 * BISECT_STEPS;
  localparam int NB     = BZ_STG + 5;

  typedef struct packed {
    item_t                    it;
    logic [UW-1:0]            r;
    logic [TW-1:0]            target;
    logic signed [XW-1:0]     span;
    logic signed [XW-1:0]     q2;
    logic [UW-1:0]            u;
    logic [UW-1:0]            step;
    logic [UW-1:0]            v;
    logic [UW-1:0]            u2;
    logic [UW-1:0]            v2;
    logic [UW-1:0]            w0;
    logic [WW-1:0]            w1;
    logic [WW-1:0]            w2;
    logic [UW-1:0]            w3;
    logic [UW-1:0]            t2;
    logic [UW-1:0]            t3;
    logic signed [CW-1:0]     c0;
    logic signed [CW-1:0]     c1;
    logic signed [CW-1:0]     c2;
    logic signed [CW-1:0]     c3;
    logic signed [QW-1:0]     q0;
    logic signed [QW-1:0]     q1;
    logic signed [QW-1:0]     q2v;
    logic signed [QW-1:0]     q3;
    logic signed [ACC_W-1:0]  p0;
    logic signed [ACC_W-1:0]  p1;
    logic signed [ACC_W-1:0]  p2;
    logic signed [ACC_W-1:0]  p3;
  } bk_t;

  function automatic bk_t f_init(fe_item_t a);
    bk_t o;
    o        = '0;
    o.it     = a.it;
    o.r      = a.r;
    o.target = a.it.d * a.r;
    o.span   = XW'(a.it.d) << FRAC_BITS;
    o.q2     = XW'(a.it.et) + o.span;
    o.u      = ONE_FX >> 1;
    o.step   = ONE_FX >> 1;
    return o;
  endfunction

  function automatic bk_t f_wa(bk_t a);
    bk_t o;
    logic [2*UW-1:0] m0, m1;
    o    = a;
    o.v  = ONE_FX - a.u;
    m0   = o.v * o.v;
    m1   = a.u * a.u;
    o.v2 = UW'(m0 >> FRAC_BITS);
    o.u2 = UW'(m1 >> FRAC_BITS);
    return o;
  endfunction

  function automatic bk_t f_wb(bk_t a);
    bk_t o;
    logic [2*UW-1:0] m0, m1, m2, m3;
    logic [UW-1:0]   h1, h2;
    o    = a;
    m0   = a.v2 * a.v;
    m1   = a.v2 * a.u;
    m2   = a.u2 * a.v;
    m3   = a.u2 * a.u;
    h1   = UW'(m1 >> FRAC_BITS);
    h2   = UW'(m2 >> FRAC_BITS);
    o.w0 = UW'(m0 >> FRAC_BITS);
    o.w1 = WW'(h1) + {h1, 1'b0};
    o.w2 = WW'(h2) + {h2, 1'b0};
    o.w3 = UW'(m3 >> FRAC_BITS);
    return o;
  endfunction

  function automatic bk_t f_xp(bk_t a);
    bk_t o;
    logic signed [ACC_W-1:0] m1, m2, m3;
    o    = a;
    m1   = $signed({1'b0, a.w1}) * a.it.st;
    m2   = $signed({1'b0, a.w2}) * a.q2;
    m3   = $signed({1'b0, a.w3}) * a.span;
    o.p1 = m1 >>> FRAC_BITS;
    o.p2 = m2 >>> FRAC_BITS;
    o.p3 = m3 >>> FRAC_BITS;
    return o;
  endfunction

  function automatic bk_t f_upd(bk_t a);
    bk_t o;
    logic signed [ACC_W-1:0] x, tgt;
    o      = a;
    x      = a.p1 + a.p2 + a.p3;
    tgt    = $signed(ACC_W'(a.target));
    o.step = a.step >> 1;
    if (x > tgt) begin
      o.u = a.u - o.step;
    end else begin
      o.u = a.u + o.step;
    end
    return o;
  endfunction

  function automatic bk_t f_t2(bk_t a);
    bk_t o;
    logic [2*UW-1:0] m;
    o    = a;
    m    = a.r * a.r;
    o.t2 = UW'(m >> FRAC_BITS);
    return o;
  endfunction

  function automatic bk_t f_t3(bk_t a);
    bk_t o;
    logic [2*UW-1:0] m;
    o    = a;
    m    = a.t2 * a.r;
    o.t3 = UW'(m >> FRAC_BITS);
    return o;
  endfunction

  function automatic bk_t f_sel(bk_t a);
    bk_t o;
    logic signed [CW-1:0] t2s, t3s, rs, ones;
    o    = a;
    t2s  = $signed(CW'(a.t2));
    t3s  = $signed(CW'(a.t3));
    rs   = $signed(CW'(a.r));
    ones = $signed(CW'(ONE_FX));
    // forward value alone unless a curve applies
    o.c0  = ones;
    o.c1  = '0;
    o.c2  = '0;
    o.c3  = '0;
    o.q0  = QW'(a.it.f);
    o.q1  = '0;
    o.q2v = '0;
    o.q3  = '0;
    if (!a.it.pass) begin
      unique case (a.it.kind)
        K_LINEAR: begin
          o.c0 = rs;
          o.q0 = QW'(a.it.b) - QW'(a.it.f);
          o.c1 = ones;
          o.q1 = QW'(a.it.f);
        end
        K_HERMITE: begin
          o.c0  = CW'(2 * t3s - 3 * t2s + ones);
          o.c1  = CW'(3 * t2s - 2 * t3s);
          o.c2  = CW'(t3s - 2 * t2s + rs);
          o.c3  = t3s - t2s;
          o.q0  = QW'(a.it.f);
          o.q1  = QW'(a.it.b);
          o.q2v = QW'(a.it.sv) - QW'(a.it.f);
          o.q3  = QW'(a.it.ev) - QW'(a.it.b);
        end
        K_BEZIER: begin
          o.c0  = $signed(CW'(a.w0));
          o.c1  = $signed(CW'(a.w1));
          o.c2  = $signed(CW'(a.w2));
          o.c3  = $signed(CW'(a.w3));
          o.q0  = QW'(a.it.f);
          o.q1  = QW'(a.it.sv) + QW'(a.it.f);
          o.q2v = QW'(a.it.ev) + QW'(a.it.b);
          o.q3  = QW'(a.it.b);
        end
        K_HOLD: begin
        end
      endcase
    end
    return o;
  endfunction

  function automatic bk_t f_evp(bk_t a);
    bk_t o;
    logic signed [ACC_W-1:0] m0, m1, m2, m3;
    o    = a;
    m0   = a.c0 * a.q0;
    m1   = a.c1 * a.q1;
    m2   = a.c2 * a.q2v;
    m3   = a.c3 * a.q3;
    o.p0 = m0 >>> FRAC_BITS;
    o.p1 = m1 >>> FRAC_BITS;
    o.p2 = m2 >>> FRAC_BITS;
    o.p3 = m3 >>> FRAC_BITS;
    return o;
  endfunction

  bk_t                     bk_d [NB];
  bk_t                     bk_q [NB];
  logic [NB-1:0]           bv_q;
  logic                    en;
  logic                    out_vld_q;
  logic signed [VAL_W-1:0] res_q, res_d;
  logic signed [ACC_W-1:0] y;
  logic [ACC_W-VAL_W:0]    y_hi;

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en;

  always_comb begin
    bk_d[0] = f_init(item_i);
    for (int s = 1; s < NB; s++) begin
      if (s <= BZ_STG) begin
        // four stages per bisection step
        case ((s - 1) % 4)
          0:       bk_d[s] = f_wa(bk_q[s-1]);
          1:       bk_d[s] = f_wb(bk_q[s-1]);
          2:       bk_d[s] = f_xp(bk_q[s-1]);
          default: bk_d[s] = f_upd(bk_q[s-1]);
        endcase
      end else if (s == BZ_STG + 1) begin
        bk_d[s] = f_t2(f_wa(bk_q[s-1]));
      end else if (s == BZ_STG + 2) begin
        bk_d[s] = f_t3(f_wb(bk_q[s-1]));
      end else if (s == BZ_STG + 3) begin
        bk_d[s] = f_sel(bk_q[s-1]);
      end else begin
        bk_d[s] = f_evp(bk_q[s-1]);
      end
    end
  end

  always_comb begin
    y    = bk_q[NB-1].p0 + bk_q[NB-1].p1 + bk_q[NB-1].p2 + bk_q[NB-1].p3;
    y_hi = y[ACC_W-1:VAL_W-1];
    if ((&y_hi) || !(|y_hi)) begin
      res_d = y[VAL_W-1:0];
    end else if (y[ACC_W-1]) begin
      res_d = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      bv_q      <= {bv_q[NB-2:0], valid_i};
      out_vld_q <= bv_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bk_q  <= bk_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule

// ----- hw/rtl/keyframe_curve_interpolator.sv -----
// Keyframe curve interpolator: takes one evaluation per clock while in_ready_o
// is high (hold, linear, cubic Hermite or cubic Bezier between two keyframes,
// Q16.16 values) and returns one saturated value per evaluation, in order.
// Throughput is one item a cycle while the output side does not stall. An item
// passes through the ratio divider (one quotient bit per stage), the four-entry
// decoupling queue, then the evaluator, where each bisection step costs four
// pipeline stages (weights, weights, products, compare). A stall on the output
// side fills the queue before the input side stalls.
`timescale 1ns / 1ps
module keyframe_curve_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic [kci_pkg::FRAME_W-1:0]         forward_frame_i,
  input  logic [kci_pkg::FRAME_W-1:0]         backward_frame_i,
  input  logic [kci_pkg::FRAME_W-1:0]         frame_no_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    forward_value_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    backward_value_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    start_time_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    start_value_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    end_time_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0]    end_value_ctl_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kci_pkg::VAL_W-1:0]    result_value_o
);
  import kci_pkg::*;

  raw_t     raw;
  fe_item_t fe_item;
  fe_item_t q_item;
  logic     push;
  logic     full;
  logic     q_valid;
  logic     pop;

  assign raw.kind = kind_e'(kind_i);
  assign raw.ff   = forward_frame_i;
  assign raw.bf   = backward_frame_i;
  assign raw.fn   = frame_no_i;
  assign raw.f    = forward_value_i;
  assign raw.b    = backward_value_i;
  assign raw.st   = start_time_ctl_i;
  assign raw.sv   = start_value_ctl_i;
  assign raw.et   = end_time_ctl_i;
  assign raw.ev   = end_value_ctl_i;

  kci_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_i      (raw),
    .push_o     (push),
    .full_i     (full),
    .item_o     (fe_item)
  );

  kci_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fe_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  kci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .pop_o       (pop),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_value_o)
  );

endmodule

// ----- hw/rtl/kci_checker.sv -----
`timescale 1ns / 1ps
`include "keyframe_curve_interpolator_macros.svh"
module kci_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [1:0]                       kind_i,
  input logic [kci_pkg::FRAME_W-1:0]      forward_frame_i,
  input logic [kci_pkg::FRAME_W-1:0]      backward_frame_i,
  input logic [kci_pkg::FRAME_W-1:0]      frame_no_i,
  input logic signed [kci_pkg::VAL_W-1:0] forward_value_i,
  input logic signed [kci_pkg::VAL_W-1:0] backward_value_i,
  input logic signed [kci_pkg::VAL_W-1:0] start_time_ctl_i,
  input logic signed [kci_pkg::VAL_W-1:0] start_value_ctl_i,
  input logic signed [kci_pkg::VAL_W-1:0] end_time_ctl_i,
  input logic signed [kci_pkg::VAL_W-1:0] end_value_ctl_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [kci_pkg::VAL_W-1:0] result_value_o
);
  import kci_pkg::*;

  localparam int MaxInFlight = FRAC_BITS + 4 * BISECT_STEPS + FIFO_DEPTH + 8;
  localparam int CntW        = $clog2(MaxInFlight + 1) + 1;

  logic [CntW-1:0] pend_q;
  logic            in_xfer;
  logic            out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items taken in but not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + CntW'(in_xfer) - CntW'(out_xfer);
    end
  end

  `KCI_ASSERT_NOW(a_no_invented, out_valid_o, pend_q != '0, "result with no pending item")
  `KCI_ASSERT_NOW(a_clear_after_reset, $past(!rst_ni), !out_valid_o, "valid straight after reset")
  `KCI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o), "stalled result changed")

endmodule

bind keyframe_curve_interpolator kci_checker u_kci_checker (.*);

// ----- tb/kci_checker.sv -----
`timescale 1ns / 1ps
module kci_scoreboard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [1:0]                       kind_i,
  input  logic [kci_pkg::FRAME_W-1:0]      forward_frame_i,
  input  logic [kci_pkg::FRAME_W-1:0]      backward_frame_i,
  input  logic [kci_pkg::FRAME_W-1:0]      frame_no_i,
  input  logic signed [kci_pkg::VAL_W-1:0] forward_value_i,
  input  logic signed [kci_pkg::VAL_W-1:0] backward_value_i,
  input  logic signed [kci_pkg::VAL_W-1:0] start_time_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0] start_value_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0] end_time_ctl_i,
  input  logic signed [kci_pkg::VAL_W-1:0] end_value_ctl_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [kci_pkg::VAL_W-1:0] result_value_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               results_o
);
  import kci_pkg::*;

  localparam longint UNIT = 64'sd1 << FRAC_BITS;
  localparam longint LMASK = UNIT - 1;
  localparam int EXP_DEPTH = 1024;

  // expected values, in transfer order
  logic signed [VAL_W-1:0] exp_mem [EXP_DEPTH];
  int wr_n, rd_n;

  function automatic longint fdiv(longint a);
    if (a >= 0) return a >>> FRAC_BITS;
    return -((-a + LMASK) >>> FRAC_BITS);
  endfunction

  function automatic longint fmul(longint w, longint q);
    return w * fdiv(q) + fdiv(w * (q & LMASK));
  endfunction

  function automatic void weights(longint u, output longint w0, output longint w1,
                                  output longint w2, output longint w3);
    longint v, v2, u2;
    v = UNIT - u;
    v2 = fmul(v, v);
    u2 = fmul(u, u);
    w0 = fmul(v2, v);
    w1 = 3 * fmul(v2, u);
    w2 = 3 * fmul(u2, v);
    w3 = fmul(u2, u);
  endfunction

  function automatic logic signed [VAL_W-1:0] interpolate(
      kind_e k, longint ff, longint bf, longint fno, longint f, longint b,
      longint st, longint sv, longint et, longint ev);
    longint d, num, r, y, t2, t3, span, tgt, q2, u, stp, x, w0, w1, w2, w3;
    if (bf <= ff || k == K_HOLD) return VAL_W'(f);
    d = bf - ff;
    num = fno - ff;
    if (num <= 0) r = 0;
    else if (num >= d) r = UNIT;
    else r = (num << FRAC_BITS) / d;
    case (k)
      K_LINEAR: y = fmul(r, b - f) + f;
      K_HERMITE: begin
        t2 = fmul(r, r);
        t3 = fmul(t2, r);
        y = fmul(2 * t3 - 3 * t2 + UNIT, f) + fmul(-2 * t3 + 3 * t2, b)
          + fmul(t3 - 2 * t2 + r, sv - f) + fmul(t3 - t2, ev - b);
      end
      default: begin
        span = d * UNIT;
        tgt = d * r;
        q2 = et + span;
        u = UNIT / 2;
        stp = UNIT / 2;
        for (int i = 0; i < BISECT_STEPS; i++) begin
          weights(u, w0, w1, w2, w3);
          x = fmul(w1, st) + fmul(w2, q2) + fmul(w3, span);
          stp = stp / 2;
          if (x > tgt) u -= stp;
          else u += stp;
        end
        weights(u, w0, w1, w2, w3);
        y = fmul(w0, f) + fmul(w1, sv + f) + fmul(w2, ev + b) + fmul(w3, b);
      end
    endcase
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return VAL_W'(y);
  endfunction

  assign pending_o = wr_n - rd_n;

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [VAL_W-1:0] want;
    if (!rst_ni) begin
      wr_n <= 0;
      rd_n <= 0;
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        exp_mem[wr_n % EXP_DEPTH] <= interpolate(kind_e'(kind_i), forward_frame_i,
                                      backward_frame_i, frame_no_i, forward_value_i,
                                      backward_value_i, start_time_ctl_i, start_value_ctl_i,
                                      end_time_ctl_i, end_value_ctl_i);
        wr_n <= wr_n + 1;
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (rd_n == wr_n) begin
          if (errors_o < 10) $display("unexpected result %0d", result_value_i);
          errors_o <= errors_o + 1;
        end else begin
          want = exp_mem[rd_n % EXP_DEPTH];
          rd_n <= rd_n + 1;
          if (want !== result_value_i) begin
            if (errors_o < 10)
              $display("result_value mismatch: expected %0d got %0d", want, result_value_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import kci_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic [1:0] kind_i = '0;
  logic [FRAME_W-1:0] forward_frame_i = '0, backward_frame_i = '0, frame_no_i = '0;
  logic signed [VAL_W-1:0] forward_value_i = '0, backward_value_i = '0;
  logic signed [VAL_W-1:0] start_time_ctl_i = '0, start_value_ctl_i = '0;
  logic signed [VAL_W-1:0] end_time_ctl_i = '0, end_value_ctl_i = '0;
  logic signed [VAL_W-1:0] result_value_o;
  int errors, pending, results;
  int idle_cycles = 0;
  int sent;

  keyframe_curve_interpolator dut (.*);

  kci_scoreboard u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .forward_frame_i,
    .backward_frame_i, .frame_no_i, .forward_value_i, .backward_value_i,
    .start_time_ctl_i, .start_value_ctl_i, .end_time_ctl_i, .end_value_ctl_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_value_i(result_value_o),
    .errors_o(errors), .pending_o(pending), .results_o(results));

  initial forever #5 clk_i = ~clk_i;

  // watchdog: ends the run with FAIL when neither side transfers, with plenty of slack over the pipe and the stalls
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL keyframe_curve_interpolator");
      $finish;
    end
  end

  // receiver: random stalls, sometimes none at all
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(int k, int ff, int bf, int fno,
                      logic [31:0] f, logic [31:0] b, logic [31:0] st, logic [31:0] sv,
                      logic [31:0] et, logic [31:0] ev, int burst);
    int gap;
    gap = (burst != 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= 2'(k); forward_frame_i <= 16'(ff); backward_frame_i <= 16'(bf);
    frame_no_i <= 16'(fno);
    forward_value_i <= f; backward_value_i <= b; start_time_ctl_i <= st;
    start_value_ctl_i <= sv; end_time_ctl_i <= et; end_value_ctl_i <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [31:0] rval();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h1ff_ffff)) - 32'sh100_0000;
    endcase
  endfunction

  initial begin
    int ff, bf, fno;
    int k;
    int burst;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: each kind, frame ordering, clamping, extremes, overflow
    for (int kk = 0; kk < 4; kk++) begin
      send(kk, 10, 20, 15, 32'h10000, 32'h50000, 32'h30000, 32'h20000, -32'sh30000,
           32'h40000, 0);
      send(kk, 20, 20, 25, 32'h12345, 32'h50000, 0, 0, 0, 0, 0);
      send(kk, 30, 10, 5, -32'sh12345, 32'h50000, 0, 0, 0, 0, 0);
      send(kk, 100, 200, 50, 32'h10000, 32'h90000, 32'h10000, 0, 0, 0, 0);
      send(kk, 100, 200, 65535, 32'h10000, 32'h90000, 0, 32'h7fffffff, 0, 0, 0);
    end
    send(int'(K_LINEAR), 0, 65535, 32767, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0);
    send(int'(K_HERMITE), 0, 3, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h80000000, 0);
    send(int'(K_BEZIER), 0, 65535, 40000, 32'hffffffff, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send(int'(K_BEZIER), 65534, 65535, 65535, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    for (int i = 0; i < 550; i++) begin
      // let the pipe drain once with the sender held back
      if (i == 275) begin
        in_valid_i <= 0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      k = $urandom_range(0, 3);
      ff = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1000);
      bf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : ff + $urandom_range(1, 300);
      fno = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                        : ff + $urandom_range(0, bf - ff + 2);
      burst = ((i % 100) < 30) ? 1 : 0;
      send(k, ff, bf, fno, rval(), rval(), rval(), rval(), rval(), rval(), burst);
    end
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d evaluations over all four curve kinds, %0d results checked,", sent,
             results);
    $display("including clamped ratios, unordered keyframes and saturating values.");
    if (errors == 0) $display("PASS keyframe_curve_interpolator");
    else $display("FAIL keyframe_curve_interpolator");
    $finish;
  end
endmodule
